@@ hdl/smsa_pkg.sv @@
// ----------------------------------------------------------------------------
// smsa_pkg
// Types and constants for the SIMD multiple-structure access sequencer.
// ----------------------------------------------------------------------------
package smsa_pkg;

  typedef enum logic [1:0] {
    STATUS_ACCESS   = 2'd0,
    STATUS_UNALLOC  = 2'd1,
    STATUS_RESERVED = 2'd2
  } status_t;

  localparam logic [3:0] OPC_ST4    = 4'b0000;
  localparam logic [3:0] OPC_ST1_X4 = 4'b0010;
  localparam logic [3:0] OPC_ST3    = 4'b0100;
  localparam logic [3:0] OPC_ST1_X3 = 4'b0110;
  localparam logic [3:0] OPC_ST1_X1 = 4'b0111;
  localparam logic [3:0] OPC_ST2    = 4'b1000;
  localparam logic [3:0] OPC_ST1_X2 = 4'b1010;

  localparam logic [1:0] SIZE_DOUBLE = 2'b11;
  localparam logic [4:0] REG_IMM     = 5'd31;

  typedef struct packed {
    logic        operation;
    logic        writeback;
    logic        full_width;
    logic [3:0]  opcode_field;
    logic [1:0]  element_size_code;
    logic [4:0]  base_reg;
    logic [4:0]  offset_reg;
    logic [4:0]  first_vector;
    logic [63:0] base_value;
    logic [63:0] offset_value;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic        access_is_load;
    logic [63:0] access_address;
    logic [4:0]  access_bytes;
    logic [4:0]  vector_reg;
    logic [3:0]  element_index;
    logic        whole_register;
    logic        writeback_valid;
    logic [4:0]  writeback_reg;
    logic [63:0] writeback_value;
    logic        last;
  } rsp_t;

  // one classified instruction, as queued between front and back
  typedef struct packed {
    status_t     status;
    logic        is_load;
    logic        whole;
    logic [63:0] base;
    logic [3:0]  last_lane;
    logic [1:0]  last_member;
    logic [4:0]  bytes;
    logic [4:0]  first_vector;
    logic        wb_valid;
    logic [4:0]  wb_reg;
    logic [63:0] wb_value;
  } desc_t;

endpackage

@@ hdl/smsa_front.sv @@
// ----------------------------------------------------------------------------
// smsa_front
// Decodes one instruction into an access descriptor: error class, loop
// bounds, access size and the post-index writeback value.
// ----------------------------------------------------------------------------
module smsa_front (
  input  smsa_pkg::req_t  req,
  output smsa_pkg::desc_t desc
);
  import smsa_pkg::*;

  logic [2:0]  selem;
  logic [2:0]  rpt;
  logic        legal;
  logic        interleaved;
  logic [4:0]  reg_bytes;
  logic [4:0]  elem_bytes;
  logic [4:0]  lanes;
  logic [6:0]  total;
  logic [63:0] step;

  always_comb begin
    selem = 3'd1;
    rpt   = 3'd1;
    legal = 1'b1;
    unique case (req.opcode_field)
      OPC_ST4:    selem = 3'd4;
      OPC_ST1_X4: rpt   = 3'd4;
      OPC_ST3:    selem = 3'd3;
      OPC_ST1_X3: rpt   = 3'd3;
      OPC_ST1_X1: rpt   = 3'd1;
      OPC_ST2:    selem = 3'd2;
      OPC_ST1_X2: rpt   = 3'd2;
      default:    legal = 1'b0;
    endcase

    interleaved = (selem != 3'd1);
    reg_bytes   = req.full_width ? 5'd16 : 5'd8;
    elem_bytes  = 5'd1 << req.element_size_code;
    lanes       = reg_bytes >> req.element_size_code;

    desc              = '0;
    desc.is_load      = req.operation;
    desc.base         = req.base_value;
    desc.first_vector = req.first_vector;
    desc.wb_reg       = req.base_reg;

    if (!legal) begin
      desc.status = STATUS_UNALLOC;
    end else if (req.element_size_code == SIZE_DOUBLE && !req.full_width && interleaved) begin
      desc.status = STATUS_RESERVED;
    end else begin
      desc.status = STATUS_ACCESS;
    end

    if (interleaved) begin
      desc.last_member = 2'(selem - 3'd1);
      desc.last_lane   = 4'(lanes - 5'd1);
      desc.bytes       = elem_bytes;
      desc.whole       = 1'b0;
    end else begin
      desc.last_member = 2'(rpt - 3'd1);
      desc.last_lane   = 4'd0;
      desc.bytes       = reg_bytes;
      desc.whole       = 1'b1;
    end

    // total bytes is members (or repeats) times one register's bytes
    total         = (7'(desc.last_member) + 7'd1) << (req.full_width ? 3'd4 : 3'd3);
    step          = (req.offset_reg == REG_IMM) ? {57'd0, total} : req.offset_value;
    desc.wb_value = req.base_value + step;
    desc.wb_valid = req.writeback && (desc.status == STATUS_ACCESS);
  end

endmodule

@@ hdl/smsa_queue.sv @@
// ----------------------------------------------------------------------------
// smsa_queue
// Short descriptor queue between the decode front and the access back end.
// ----------------------------------------------------------------------------
module smsa_queue #(
  parameter int Depth = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  smsa_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output smsa_pkg::desc_t head,
  output logic            head_valid
);
  import smsa_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  desc_t           entries [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;
  logic            do_push;
  logic            do_pop;

  assign full       = (count == CntFull);
  assign head_valid = (count != '0);
  assign head       = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CntW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

@@ hdl/smsa_back.sv @@
// ----------------------------------------------------------------------------
// smsa_back
// Walks the lane and member counters of the head descriptor and issues one
// access beat per cycle into the output register whenever that register is empty or being taken.
// ----------------------------------------------------------------------------
module smsa_back (
  input  logic            clk,
  input  logic            rst,
  input  smsa_pkg::desc_t head,
  input  logic            head_valid,
  output logic            pop,
  output smsa_pkg::rsp_t  rsp,
  output logic            rsp_valid,
  input  logic            rsp_ready
);
  import smsa_pkg::*;

  logic [3:0] lane;
  logic [1:0] member;
  logic [6:0] offset;
  logic       advance;
  logic       final_beat;
  rsp_t       rsp_next;

  assign advance    = head_valid && (!rsp_valid || rsp_ready);
  assign final_beat = (head.status != STATUS_ACCESS) ||
                      (lane == head.last_lane && member == head.last_member);
  assign pop        = advance && final_beat;

  always_comb begin
    rsp_next      = '0;
    rsp_next.last = final_beat;
    if (head.status != STATUS_ACCESS) begin
      rsp_next.status = head.status;
    end else begin
      rsp_next.status         = STATUS_ACCESS;
      rsp_next.access_is_load = head.is_load;
      rsp_next.access_address = head.base + {57'd0, offset};
      rsp_next.access_bytes   = head.bytes;
      rsp_next.vector_reg     = head.first_vector + {3'd0, member};
      rsp_next.element_index  = lane;
      rsp_next.whole_register = head.whole;
      if (final_beat && head.wb_valid) begin
        rsp_next.writeback_valid = 1'b1;
        rsp_next.writeback_reg   = head.wb_reg;
        rsp_next.writeback_value = head.wb_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lane      <= '0;
      member    <= '0;
      offset    <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (advance) begin
        rsp_valid <= 1'b1;
        if (final_beat) begin
          lane   <= '0;
          member <= '0;
          offset <= '0;
        end else begin
          offset <= offset + {2'd0, head.bytes};
          if (member == head.last_member) begin
            member <= '0;
            lane   <= lane + 4'd1;
          end else begin
            member <= member + 2'd1;
          end
        end
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= rsp_next;
    end
  end

endmodule

@@ hdl/simd_multiple_structure_access_sequencer.sv @@
// ----------------------------------------------------------------------------
// simd_multiple_structure_access_sequencer
// Expands one LD1-LD4 / ST1-ST4 (multiple structures) instruction into its
// ordered memory access beats.
// ----------------------------------------------------------------------------
// An instruction is decoded on acceptance and parked in a short queue; the
// back end then issues one access beat per cycle from it while the receiver
// keeps up, so an instruction yields 1 to 64 beats (number of registers for
// the whole register forms, lanes times members for the interleaved forms,
// one beat for an illegal or reserved encoding). The one-beat-per-cycle
// access counter of the back end sets the sustained rate when the output is
// not stalled; the instruction being expanded holds its queue slot until its
// last beat issues, so up to QueueDepth - 1 further instructions can be
// accepted meanwhile. Writeback rides on the beat flagged last.
module simd_multiple_structure_access_sequencer #(
  parameter int QueueDepth = 2
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  smsa_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output smsa_pkg::rsp_t rsp
);
  import smsa_pkg::*;

  desc_t dec_desc;
  desc_t head;
  logic  head_valid;
  logic  q_full;
  logic  pop;

  assign req_ready = !q_full;

  smsa_front u_front (
    .req  (req),
    .desc (dec_desc)
  );

  smsa_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (req_valid && req_ready),
    .push_data  (dec_desc),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .head_valid (head_valid)
  );

  smsa_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .head_valid (head_valid),
    .pop        (pop),
    .rsp        (rsp),
    .rsp_valid  (rsp_valid),
    .rsp_ready  (rsp_ready)
  );

  a_error_single_beat : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != STATUS_ACCESS |-> rsp.last && !rsp.writeback_valid)
    else $error("error beat not a single last beat");

  a_wb_only_last : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.writeback_valid |-> rsp.last)
    else $error("writeback on a non-last beat");

  a_whole_index_zero : assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.whole_register |-> rsp.element_index == 4'd0)
    else $error("whole register beat with nonzero lane");

  a_pop_on_beat : assert property (@(posedge clk) disable iff (rst)
    pop |=> rsp_valid && rsp.last)
    else $error("descriptor retired without a last beat");

endmodule

@@ tb/sv/smsa_access_checker.sv @@
// ----------------------------------------------------------------------------
// smsa_access_checker
// Watches both channels of the access sequencer, expands every accepted
// instruction into its expected access beats and compares each returned
// beat, field by field, against the oldest expected one.
// ----------------------------------------------------------------------------
module smsa_access_checker (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  input  logic           req_ready,
  input  smsa_pkg::req_t req,
  input  logic           rsp_valid,
  input  logic           rsp_ready,
  input  smsa_pkg::rsp_t rsp,
  output int             fail_count,
  output int             outstanding,
  output int             instr_count,
  output int             beat_count,
  output int             error_beats
);
  timeunit 1ns;
  timeprecision 1ps;
  import smsa_pkg::*;

  localparam int MAX_REPORTS = 10;

  rsp_t pending_accesses[$];

  function automatic void expand_instruction(input req_t r);
    int unsigned repeats;
    int unsigned members;
    int unsigned beats;
    int unsigned reg_bytes;
    int unsigned stride;
    int unsigned i;
    logic        whole;
    logic [63:0] step;
    rsp_t        beat;
    repeats = 1;
    members = 1;
    beat = '0;
    case (r.opcode_field)
      OPC_ST4:    members = 4;
      OPC_ST1_X4: repeats = 4;
      OPC_ST3:    members = 3;
      OPC_ST1_X3: repeats = 3;
      OPC_ST1_X1: repeats = 1;
      OPC_ST2:    members = 2;
      OPC_ST1_X2: repeats = 2;
      default: begin
        beat.status = STATUS_UNALLOC;
        beat.last = 1'b1;
        pending_accesses.push_back(beat);
        return;
      end
    endcase
    if (r.element_size_code == SIZE_DOUBLE && !r.full_width && members != 1) begin
      beat.status = STATUS_RESERVED;
      beat.last = 1'b1;
      pending_accesses.push_back(beat);
      return;
    end
    reg_bytes = r.full_width ? 16 : 8;
    whole = (members == 1);
    stride = whole ? reg_bytes : (1 << r.element_size_code);
    beats = whole ? repeats : (reg_bytes / stride) * members;
    step = (r.offset_reg == REG_IMM) ? 64'(beats * stride) : r.offset_value;
    for (i = 0; i < beats; i++) begin
      beat = '0;
      beat.status = STATUS_ACCESS;
      beat.access_is_load = r.operation;
      beat.access_address = r.base_value + 64'(i * stride);
      beat.access_bytes = 5'(stride);
      beat.whole_register = whole;
      if (whole) begin
        beat.vector_reg = r.first_vector + 5'(i);
      end else begin
        beat.vector_reg = r.first_vector + 5'(i % members);
        beat.element_index = 4'(i / members);
      end
      if (i == beats - 1) begin
        beat.last = 1'b1;
        if (r.writeback) begin
          beat.writeback_valid = 1'b1;
          beat.writeback_reg = r.base_reg;
          beat.writeback_value = r.base_value + step;
        end
      end
      pending_accesses.push_back(beat);
    end
  endfunction

  task automatic check_field(input string field, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      if (fail_count < MAX_REPORTS)
        $display("mismatch on beat %0d, %s: expected %h, got %h",
                 beat_count, field, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst) begin
      if (rsp_valid && rsp_ready) begin
        if (pending_accesses.size() == 0) begin
          if (fail_count < MAX_REPORTS)
            $display("beat %0d arrived with nothing pending: %p", beat_count, rsp);
          fail_count++;
        end else begin
          want = pending_accesses.pop_front();
          check_field("status", want.status, rsp.status);
          check_field("access_is_load", want.access_is_load, rsp.access_is_load);
          check_field("access_address", want.access_address, rsp.access_address);
          check_field("access_bytes", want.access_bytes, rsp.access_bytes);
          check_field("vector_reg", want.vector_reg, rsp.vector_reg);
          check_field("element_index", want.element_index, rsp.element_index);
          check_field("whole_register", want.whole_register, rsp.whole_register);
          check_field("writeback_valid", want.writeback_valid, rsp.writeback_valid);
          check_field("writeback_reg", want.writeback_reg, rsp.writeback_reg);
          check_field("writeback_value", want.writeback_value, rsp.writeback_value);
          check_field("last", want.last, rsp.last);
        end
        if (rsp.status != STATUS_ACCESS) error_beats++;
        beat_count++;
      end
      if (req_valid && req_ready) begin
        expand_instruction(req);
        instr_count++;
      end
    end
    outstanding <= pending_accesses.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives LD1-LD4 / ST1-ST4 multiple-structure instructions into the access
// sequencer: a directed set of corner encodings, then random instructions
// under several sender idle and receiver stall mixes, including one long
// receiver hold-off. The checker module predicts and compares the beats.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import smsa_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 20;
  localparam int PHASE_ITEMS    = 40;
  localparam int PRESSURE_ITEMS = 15;

  localparam logic [1:0] SIZE_BYTE = 2'd0;
  localparam logic [1:0] SIZE_HALF = 2'd1;
  localparam logic [1:0] SIZE_WORD = 2'd2;

  localparam logic [3:0] OPC_UNUSED_1  = 4'b0001;
  localparam logic [3:0] OPC_UNUSED_11 = 4'b1011;
  localparam logic [3:0] OPC_UNUSED_15 = 4'b1111;

  localparam logic [3:0] LEGAL_OPCODES [7] = '{
    OPC_ST4, OPC_ST1_X4, OPC_ST3, OPC_ST1_X3, OPC_ST1_X1, OPC_ST2, OPC_ST1_X2
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  req_t req = '0;
  logic rsp_ready = 1'b0;
  logic req_ready;
  logic rsp_valid;
  rsp_t rsp;

  int   sender_idle_pct = 0;
  int   receiver_stall_pct = 0;
  logic hold_request = 1'b0;
  int   quiet_cycles = 0;

  int fail_count;
  int outstanding;
  int instr_count;
  int beat_count;
  int error_beats;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  simd_multiple_structure_access_sequencer i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  smsa_access_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .instr_count (instr_count),
    .beat_count  (beat_count),
    .error_beats (error_beats)
  );

  function automatic req_t make_req(input logic op, input logic wb, input logic q,
                                    input logic [3:0] opc, input logic [1:0] sz,
                                    input logic [4:0] rn, input logic [4:0] rm,
                                    input logic [4:0] vt, input logic [63:0] base,
                                    input logic [63:0] off);
    req_t r;
    r.operation = op;
    r.writeback = wb;
    r.full_width = q;
    r.opcode_field = opc;
    r.element_size_code = sz;
    r.base_reg = rn;
    r.offset_reg = rm;
    r.first_vector = vt;
    r.base_value = base;
    r.offset_value = off;
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    r.operation = 1'($urandom);
    r.writeback = 1'($urandom);
    r.full_width = 1'($urandom);
    r.opcode_field = ($urandom_range(99) < 85) ? LEGAL_OPCODES[$urandom_range(6)]
                                               : 4'($urandom);
    r.element_size_code = 2'($urandom);
    r.base_reg = 5'($urandom);
    r.offset_reg = ($urandom_range(99) < 35) ? REG_IMM : 5'($urandom);
    r.first_vector = 5'($urandom);
    r.base_value = ($urandom_range(99) < 20) ? ~64'($urandom_range(255))
                                             : {$urandom, $urandom};
    r.offset_value = {$urandom, $urandom};
    return r;
  endfunction

  // valid drops only when a gap is taken, so it never falls and rises in one step
  task automatic send_item(input req_t item);
    if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
      req_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    req <= item;
    req_valid <= 1'b1;
    do @(posedge clk); while (!req_ready);
  endtask

  task automatic run_phase(input int items, input int idle_pct, input int stall_pct);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (items) send_item(random_req());
  endtask

  // receiver: random stalls, plus one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        rsp_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
      end
      rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles, %0d beats still expected",
               WATCHDOG_LIMIT, outstanding);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed corners, no idling
    send_item(make_req(1'b0, 1'b0, 1'b1, OPC_ST4, SIZE_BYTE, 5'd1, 5'd2, 5'd30,
                       64'h1000, 64'h0));
    send_item(make_req(1'b1, 1'b1, 1'b1, OPC_ST4, SIZE_BYTE, 5'd3, REG_IMM, 5'd0,
                       ~64'h1f, 64'h0));
    send_item(make_req(1'b1, 1'b1, 1'b1, OPC_ST1_X4, SIZE_WORD, 5'd7, 5'd5, 5'd29,
                       64'h8000_0000_0000_0000, 64'hffff_ffff_ffff_fff0));
    send_item(make_req(1'b0, 1'b1, 1'b0, OPC_ST3, SIZE_HALF, REG_IMM, REG_IMM, 5'd31,
                       64'h2000, 64'h0));
    send_item(make_req(1'b1, 1'b0, 1'b0, OPC_ST1_X3, SIZE_DOUBLE, 5'd4, 5'd9, 5'd30,
                       64'h3000, 64'h55));
    send_item(make_req(1'b0, 1'b1, 1'b0, OPC_ST1_X1, SIZE_DOUBLE, 5'd8, REG_IMM, 5'd12,
                       ~64'h3, 64'h0));
    send_item(make_req(1'b1, 1'b1, 1'b1, OPC_ST2, SIZE_DOUBLE, 5'd10, 5'd11, 5'd31,
                       64'h4000, 64'h1234_5678_9abc_def0));
    send_item(make_req(1'b0, 1'b0, 1'b1, OPC_ST1_X2, SIZE_WORD, 5'd12, 5'd13, 5'd31,
                       64'h5000, 64'h0));
    send_item(make_req(1'b1, 1'b1, 1'b1, OPC_ST2, SIZE_BYTE, 5'd14, REG_IMM, 5'd6,
                       64'h6000, 64'h0));
    send_item(make_req(1'b0, 1'b1, 1'b0, OPC_ST3, SIZE_WORD, 5'd15, 5'd16, 5'd2,
                       64'h7000, 64'h40));
    send_item(make_req(1'b0, 1'b1, 1'b1, OPC_UNUSED_1, SIZE_BYTE, 5'd17, 5'd18, 5'd3,
                       64'h8000, 64'h10));
    send_item(make_req(1'b1, 1'b0, 1'b0, OPC_UNUSED_11, SIZE_HALF, 5'd19, REG_IMM,
                       5'd4, 64'h9000, 64'h0));
    send_item(make_req(1'b1, 1'b1, 1'b1, OPC_UNUSED_15, SIZE_DOUBLE, REG_IMM, REG_IMM,
                       REG_IMM, '1, '1));
    send_item(make_req(1'b0, 1'b1, 1'b0, OPC_ST4, SIZE_DOUBLE, 5'd20, REG_IMM, 5'd5,
                       64'ha000, 64'h0));
    send_item(make_req(1'b1, 1'b1, 1'b0, OPC_ST2, SIZE_DOUBLE, 5'd21, 5'd22, 5'd6,
                       64'hb000, 64'h8));
    send_item(make_req(1'b0, 1'b0, 1'b0, OPC_ST3, SIZE_DOUBLE, 5'd23, 5'd24, 5'd7,
                       64'hc000, 64'h0));
    send_item(make_req(1'b1, 1'b1, 1'b1, OPC_ST1_X4, SIZE_DOUBLE, REG_IMM, 5'd30,
                       REG_IMM, '1, '1));
    send_item(make_req(1'b0, 1'b0, 1'b0, OPC_ST4, SIZE_BYTE, 5'd0, 5'd0, 5'd0,
                       64'h0, 64'h0));
    send_item(make_req(1'b1, 1'b1, 1'b0, OPC_ST1_X1, SIZE_BYTE, 5'd25, 5'd26, 5'd27,
                       64'h0, '1));

    // long receiver hold-off while instructions keep coming
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_request = 1'b1;
    repeat (PRESSURE_ITEMS) send_item(random_req());

    run_phase(PHASE_ITEMS - PRESSURE_ITEMS, 0, 0);
    run_phase(PHASE_ITEMS, 67, 0);
    run_phase(PHASE_ITEMS, 0, 67);
    run_phase(PHASE_ITEMS, 20, 20);

    req_valid <= 1'b0;
    receiver_stall_pct = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d instructions, %0d access beats (%0d error results)",
             instr_count, beat_count, error_beats);
    $display({"under free-running, sender-idle, receiver-stall and mixed traffic",
              " plus one long output hold-off"});
    if (fail_count == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d beats never arrived", fail_count, outstanding);
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ simd_multiple_structure_access_sequencer.f @@
hdl/smsa_pkg.sv
hdl/smsa_front.sv
hdl/smsa_queue.sv
hdl/smsa_back.sv
hdl/simd_multiple_structure_access_sequencer.sv
tb/sv/smsa_access_checker.sv
tb/sv/testbench.sv
